@@ rtl/mouse_report_to_serial_packets_core_defines.svh @@
// Assertion macros for the checker of the serial mouse encoder.
`ifndef MOUSE_REPORT_TO_SERIAL_PACKETS_CORE_DEFINES_SVH
`define MOUSE_REPORT_TO_SERIAL_PACKETS_CORE_DEFINES_SVH

// Property checked at every rising edge, switched off while reset is asserted.
`define MRSP_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked at every rising edge, reset included.
`define MRSP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/mrsp_pkg.sv @@
package mrsp_pkg;

  localparam int unsigned GapW    = 6;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned BtnW    = 3;
  localparam int unsigned CfgIdxW = 2;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_HEAD_GAP  = 2'd0,
    CFG_TAIL_GAP  = 2'd1,
    CFG_START_GAP = 2'd2
  } cfg_idx_e;

  // Item codes on the func field.
  localparam logic FUNC_REPORT = 1'b0;
  localparam logic FUNC_TICK   = 1'b1;

  localparam logic [GapW-1:0]  HEAD_GAP_RST  = 6'd25;
  localparam logic [GapW-1:0]  TAIL_GAP_RST  = 6'd15;
  localparam logic [GapW-1:0]  START_GAP_RST = 6'd40;
  localparam logic [GapW-1:0]  ELAPSED_MAX   = 6'd63;
  localparam logic [BtnW-1:0]  BTN_IDLE      = 3'b111;
  localparam logic [ByteW-1:0] HEAD_FLAG     = 8'h80;
  localparam logic [ByteW-1:0] ACC_MAX       = 8'h7f;
  localparam logic [ByteW-1:0] ACC_MIN       = 8'h81;

  // One packet handed from the encoder to the serializer.
  typedef struct packed {
    logic             vld;
    logic             head;
    logic [BtnW-1:0]  btn;
    logic [ByteW-1:0] dx;
    logic [ByteW-1:0] dy;
  } pkt_t;

  // Clamp a 9-bit signed sum to the -127..127 accumulator range.
  function automatic logic [ByteW-1:0] sat_acc(logic signed [ByteW:0] s);
    logic [ByteW-1:0] r;
    if (s > 9'sd127) begin
      r = ACC_MAX;
    end else if (s < -9'sd127) begin
      r = ACC_MIN;
    end else begin
      r = s[ByteW-1:0];
    end
    return r;
  endfunction

endpackage

@@ rtl/mrsp_if.sv @@
// Input channel: mouse reports and millisecond ticks.
interface mrsp_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] report_buttons;
  logic signed [7:0] move_x;
  logic signed [7:0] move_y;

  modport source (output valid, func, report_buttons, move_x, move_y, input ready);
  modport sink   (input valid, func, report_buttons, move_x, move_y, output ready);
endinterface

// Output channel: serial bytes.
interface mrsp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last;

  modport source (output valid, out_byte, last, input ready);
  modport sink   (input valid, out_byte, last, output ready);
endinterface

@@ rtl/mrsp_encoder.sv @@
module mrsp_encoder (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [mrsp_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  logic [mrsp_pkg::GapW-1:0]           cfg_data_i,
  input  logic                                acc_i,
  input  logic                                func_i,
  input  logic [mrsp_pkg::ByteW-1:0]          buttons_i,
  input  logic signed [mrsp_pkg::ByteW-1:0]   move_x_i,
  input  logic signed [mrsp_pkg::ByteW-1:0]   move_y_i,
  output mrsp_pkg::pkt_t                      pkt_o
);

  logic [mrsp_pkg::GapW-1:0]  head_gap_q, head_gap_d;
  logic [mrsp_pkg::GapW-1:0]  tail_gap_q, tail_gap_d;
  logic [mrsp_pkg::GapW-1:0]  start_gap_q, start_gap_d;
  logic [mrsp_pkg::GapW-1:0]  gap_q, gap_d;
  logic [mrsp_pkg::GapW-1:0]  elapsed_q, elapsed_d;
  logic [mrsp_pkg::BtnW-1:0]  btn_q, btn_d;
  logic [mrsp_pkg::ByteW-1:0] acc_x_q, acc_x_d;
  logic [mrsp_pkg::ByteW-1:0] acc_y_q, acc_y_d;
  logic                       pending_q, pending_d;
  logic                       in_tail_q, in_tail_d;

  logic [mrsp_pkg::GapW:0]    e_inc;
  logic [mrsp_pkg::GapW:0]    e_sub;
  logic [mrsp_pkg::GapW-1:0]  e_next;
  logic                       expired;
  logic signed [mrsp_pkg::ByteW:0] sum_x;
  logic signed [mrsp_pkg::ByteW:0] sum_y;
  logic                       fire;

  // Interval timer: one more millisecond, wrap by the gap, saturate.
  assign e_inc   = {1'b0, elapsed_q} + 7'd1;
  assign expired = (e_inc >= {1'b0, gap_q});
  assign e_sub   = expired ? (e_inc - {1'b0, gap_q}) : e_inc;
  assign e_next  = e_sub[mrsp_pkg::GapW] ? mrsp_pkg::ELAPSED_MAX : e_sub[mrsp_pkg::GapW-1:0];

  // Movement accumulation, y is negated.
  assign sum_x = $signed({acc_x_q[mrsp_pkg::ByteW-1], acc_x_q})
               + $signed({move_x_i[mrsp_pkg::ByteW-1], move_x_i});
  assign sum_y = $signed({acc_y_q[mrsp_pkg::ByteW-1], acc_y_q})
               - $signed({move_y_i[mrsp_pkg::ByteW-1], move_y_i});

  assign fire = acc_i && (func_i == mrsp_pkg::FUNC_TICK) && expired && pending_q;

  // Packet taken from the state as it stands before this tick.
  assign pkt_o.vld  = fire;
  assign pkt_o.head = !in_tail_q;
  assign pkt_o.btn  = btn_q;
  assign pkt_o.dx   = acc_x_q;
  assign pkt_o.dy   = acc_y_q;

  // Next-state logic for items and configuration writes.
  always_comb begin
    head_gap_d  = head_gap_q;
    tail_gap_d  = tail_gap_q;
    start_gap_d = start_gap_q;
    gap_d       = gap_q;
    elapsed_d   = elapsed_q;
    btn_d       = btn_q;
    acc_x_d     = acc_x_q;
    acc_y_d     = acc_y_q;
    pending_d   = pending_q;
    in_tail_d   = in_tail_q;

    if (acc_i) begin
      if (func_i == mrsp_pkg::FUNC_REPORT) begin
        // Buttons become the active-low code: left=4, middle=2, right=1.
        btn_d     = {~buttons_i[0], ~buttons_i[2], ~buttons_i[1]};
        acc_x_d   = mrsp_pkg::sat_acc(sum_x);
        acc_y_d   = mrsp_pkg::sat_acc(sum_y);
        pending_d = 1'b1;
      end else begin
        elapsed_d = e_next;
        if (fire) begin
          acc_x_d = '0;
          acc_y_d = '0;
          if (in_tail_q) begin
            in_tail_d = 1'b0;
            gap_d     = tail_gap_q;
            pending_d = (btn_q != mrsp_pkg::BTN_IDLE);
          end else begin
            btn_d     = mrsp_pkg::BTN_IDLE;
            in_tail_d = 1'b1;
            gap_d     = head_gap_q;
          end
        end
      end
    end

    if (cfg_we_i) begin
      case (cfg_idx_i)
        mrsp_pkg::CFG_HEAD_GAP: head_gap_d = cfg_data_i;
        mrsp_pkg::CFG_TAIL_GAP: tail_gap_d = cfg_data_i;
        mrsp_pkg::CFG_START_GAP: begin
          start_gap_d = cfg_data_i;
          gap_d       = cfg_data_i;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_gap_q  <= mrsp_pkg::HEAD_GAP_RST;
      tail_gap_q  <= mrsp_pkg::TAIL_GAP_RST;
      start_gap_q <= mrsp_pkg::START_GAP_RST;
      gap_q       <= mrsp_pkg::START_GAP_RST;
      elapsed_q   <= '0;
      btn_q       <= mrsp_pkg::BTN_IDLE;
      acc_x_q     <= '0;
      acc_y_q     <= '0;
      pending_q   <= 1'b0;
      in_tail_q   <= 1'b0;
    end else begin
      head_gap_q  <= head_gap_d;
      tail_gap_q  <= tail_gap_d;
      start_gap_q <= start_gap_d;
      gap_q       <= gap_d;
      elapsed_q   <= elapsed_d;
      btn_q       <= btn_d;
      acc_x_q     <= acc_x_d;
      acc_y_q     <= acc_y_d;
      pending_q   <= pending_d;
      in_tail_q   <= in_tail_d;
    end
  end

endmodule

@@ rtl/mrsp_serializer.sv @@
module mrsp_serializer (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  mrsp_pkg::pkt_t             pkt_i,
  output logic                       ready_o,
  output logic                       out_valid_o,
  output logic [mrsp_pkg::ByteW-1:0] out_byte_o,
  output logic                       out_last_o,
  input  logic                       out_ready_i
);

  logic [1:0]                           cnt_q, cnt_d;
  logic [2:0][mrsp_pkg::ByteW-1:0]      seq_q, seq_d;
  logic                                 pop;

  // Bytes left to send; the front byte sits at position zero.
  assign out_valid_o = (cnt_q != 2'd0);
  assign out_last_o  = (cnt_q == 2'd1);
  assign out_byte_o  = seq_q[0];
  assign pop         = out_valid_o && out_ready_i;

  // A new packet may load once the buffer drains or its last byte leaves now.
  assign ready_o = (cnt_q == 2'd0) || (out_last_o && out_ready_i);

  // Load a packet or shift one byte out per transfer.
  always_comb begin
    cnt_d = cnt_q;
    seq_d = seq_q;
    if (pkt_i.vld) begin
      if (pkt_i.head) begin
        seq_d[0] = mrsp_pkg::HEAD_FLAG | {5'b0, pkt_i.btn};
        seq_d[1] = pkt_i.dx;
        seq_d[2] = pkt_i.dy;
        cnt_d    = 2'd3;
      end else begin
        seq_d[0] = pkt_i.dx;
        seq_d[1] = pkt_i.dy;
        cnt_d    = 2'd2;
      end
    end else if (pop) begin
      seq_d[0] = seq_q[1];
      seq_d[1] = seq_q[2];
      cnt_d    = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    seq_q <= seq_d;
  end

endmodule

@@ rtl/mouse_report_to_serial_packets_core.sv @@
// Serial mouse packet encoder.
// in_i carries reports (func 0) and one-millisecond ticks (func 1); out_o
// delivers the serial byte stream, one byte per transfer, with last set on
// the final byte of each packet. A tick whose interval runs out while data
// is pending produces a 3-byte head packet or a 2-byte tail packet.
// Registers (cfg_we_i, cfg_idx_i, cfg_data_i): 0 head gap, 1 tail gap,
// 2 start gap (also loads the running interval); write them while idle.
// The first byte of a packet is valid in the cycle right after the tick
// transfer. Reports and ticks without output leave in_i.ready high. A
// tick that emits a packet keeps in_i.ready low while the single packet
// buffer drains; in_i.ready comes back in the cycle of the last byte.
// When the receiver stalls, the current byte holds and, once a packet is
// buffered, no further item is accepted until its last byte is taken.
// Reset empties the buffer, clears the other state, loads the default gaps
// (25, 15, 40 ms) and starts in the head phase with no data pending.
module mouse_report_to_serial_packets_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [mrsp_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [mrsp_pkg::GapW-1:0]     cfg_data_i,
  mrsp_in_if.sink                       in_i,
  mrsp_out_if.source                    out_o
);

  mrsp_pkg::pkt_t pkt;
  logic           ser_ready;
  logic           in_xfer;

  assign in_i.ready = ser_ready;
  assign in_xfer    = in_i.valid && ser_ready;

  mrsp_encoder u_encoder (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .acc_i      (in_xfer),
    .func_i     (in_i.func),
    .buttons_i  (in_i.report_buttons),
    .move_x_i   (in_i.move_x),
    .move_y_i   (in_i.move_y),
    .pkt_o      (pkt)
  );

  mrsp_serializer u_serializer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pkt_i       (pkt),
    .ready_o     (ser_ready),
    .out_valid_o (out_o.valid),
    .out_byte_o  (out_o.out_byte),
    .out_last_o  (out_o.last),
    .out_ready_i (out_o.ready)
  );

endmodule

@@ rtl/mrsp_checker.sv @@
`include "mouse_report_to_serial_packets_core_defines.svh"

module mrsp_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       in_func_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] out_byte_i,
  input logic       out_last_i
);

  logic in_xfer;
  assign in_xfer = in_valid_i && in_ready_i;

  // Nothing is offered on the output while reset is held.
  `MRSP_ASSERT_ALWAYS(a_no_out_in_reset, clk_i, !rst_ni |-> !out_valid_i, "output valid in reset")

  // A stalled byte holds.
  `MRSP_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_byte_i) && $stable(out_last_i), "stalled byte changed")

  // Bytes of one packet follow without a gap.
  `MRSP_ASSERT(a_pkt_contig, clk_i, rst_ni, out_valid_i && out_ready_i && !out_last_i |=> out_valid_i, "gap inside a packet")

  // No item is taken while more than one byte of a packet is left.
  `MRSP_ASSERT(a_no_in_mid_pkt, clk_i, rst_ni, out_valid_i && !out_last_i |-> !in_ready_i, "input ready mid packet")

  // A report never starts a packet.
  `MRSP_ASSERT(a_report_silent, clk_i, rst_ni, in_xfer && (in_func_i == mrsp_pkg::FUNC_REPORT) && !out_valid_i |=> !out_valid_i, "report produced output")

endmodule

bind mouse_report_to_serial_packets_core mrsp_checker u_mrsp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_func_i   (in_i.func),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_byte_i  (out_o.out_byte),
  .out_last_i  (out_o.last)
);
